### src/sprite_quad_vertex_generator_macros.svh
// Assertion macros for the sprite quad vertex generator
`ifndef SPRITE_QUAD_VERTEX_GENERATOR_MACROS_SVH
`define SPRITE_QUAD_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication
`define SQVG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sqvg assertion failed");

// next-cycle implication
`define SQVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sqvg assertion failed");

`endif

### src/sqvg_pkg.sv
// Types, constants and table functions of the sprite quad vertex generator
package sqvg_pkg;

  localparam int unsigned SINE_DEPTH_DEF  = 1024;
  localparam int unsigned MAX_TEX_DIM_DEF = 4096;
  localparam int          CORDIC_STEPS    = 28;

  localparam longint ATAN_UNITS [CORDIC_STEPS] = '{
    536870912, 316933406, 167458908, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  localparam int DIM_W = 13;
  localparam int NUM_W = 31;
  localparam int QUO_W = 18;

  typedef enum logic [1:0] {
    CFG_TEX_W = 2'd0,
    CFG_TEX_H = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        rotation;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [12:0]        size_w;
    logic [12:0]        size_h;
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [8:0]         anchor_x;
    logic [8:0]         anchor_y;
    logic [1:0]         flip;
  } item_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               last;
  } vtx_t;

  // geometry of one corner beat
  typedef struct packed {
    logic [1:0]         corner;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] lx;
    logic signed [23:0] ly;
    logic signed [15:0] scx;
    logic signed [15:0] scy;
    logic signed [15:0] cosv;
    logic signed [15:0] sinv;
  } geo_t;

  // long division state of one lane
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             sat;
  } div_t;

  function automatic logic signed [15:0] to_q14(longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return 16'(r);
  endfunction

  // {cos, sin} in Q1.14 for a 32 bit angle
  function automatic logic [31:0] cordic_sincos(longint a);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    logic   neg;
    x   = 64'sd652032874;
    y   = 64'sd0;
    neg = 1'b0;
    if (a >= 64'sd1073741824 && a < 64'sd3221225472) begin
      z   = a - 64'sd2147483648;
      neg = 1'b1;
    end else if (a < 64'sd1073741824) begin
      z = a;
    end else begin
      z = a - 64'sd4294967296;
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_UNITS[k];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_UNITS[k];
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    return {to_q14(x), to_q14(y)};
  endfunction

endpackage

### src/sqvg_div_stage.sv
// One pipeline stage of the restoring divider for texture coordinates
module sqvg_div_stage #(
  parameter int FIRST_BIT = 17,
  parameter int STEPS     = 5
) (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic [sqvg_pkg::DIM_W-1:0]    dim_i,
  input  sqvg_pkg::div_t                d_i,
  output sqvg_pkg::div_t                d_o
);

  sqvg_pkg::div_t d_d;
  sqvg_pkg::div_t d_q;

  always_comb begin
    logic [sqvg_pkg::NUM_W-1:0] sub;
    d_d = d_i;
    for (int s = 0; s < STEPS; s++) begin
      sub = sqvg_pkg::NUM_W'(dim_i) << (FIRST_BIT - s);
      if (d_d.rem >= sub) begin
        d_d.rem                 = d_d.rem - sub;
        d_d.quo[FIRST_BIT - s]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

### src/sqvg_front.sv
// Sprite holding stage, corner expansion, sine table and local corner set-up
module sqvg_front #(
  parameter int unsigned SINE_TABLE_DEPTH = sqvg_pkg::SINE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sqvg_pkg::item_t            in_data_i,
  input  logic                       adv_i,
  input  logic [sqvg_pkg::DIM_W-1:0] tex_w_i,
  input  logic [sqvg_pkg::DIM_W-1:0] tex_h_i,
  output logic                       a_valid_o,
  output sqvg_pkg::geo_t             geo_o,
  output sqvg_pkg::div_t             udiv_o,
  output sqvg_pkg::div_t             vdiv_o
);

  localparam int IDX_W  = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
  localparam int PROD_W = 16 + $clog2(SINE_TABLE_DEPTH + 1);

  logic [31:0] rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam longint ANG = (longint'(g) <<< 32) / SINE_TABLE_DEPTH;
    assign rom[g] = sqvg_pkg::cordic_sincos(ANG);
  end

  sqvg_pkg::item_t  item_q;
  logic             hv_q;
  logic [1:0]       k_q;
  logic [IDX_W-1:0] idx_q;
  logic [PROD_W-1:0] prod;
  logic             accept;
  logic             emit;

  assign prod       = PROD_W'(in_data_i.rotation) * PROD_W'(SINE_TABLE_DEPTH);
  assign emit       = hv_q && adv_i;
  assign in_ready_o = !hv_q || (emit && k_q == 2'd3);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0;
      k_q  <= 2'd0;
    end else begin
      if (accept) begin
        hv_q <= 1'b1;
        k_q  <= 2'd0;
      end else if (emit) begin
        k_q <= k_q + 2'd1;
        if (k_q == 2'd3) begin
          hv_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      idx_q  <= prod[16 +: IDX_W];
    end
  end

  // corner set-up
  logic               xi;
  logic               yi;
  logic signed [10:0] fx;
  logic signed [10:0] fy;
  logic signed [24:0] lx_w;
  logic signed [24:0] ly_w;
  logic [13:0]        eu;
  logic [13:0]        ev;
  sqvg_pkg::geo_t     geo_d;
  sqvg_pkg::div_t     udiv_d;
  sqvg_pkg::div_t     vdiv_d;

  always_comb begin
    xi   = !k_q[1];
    yi   = k_q[0] ^ k_q[1];
    fx   = xi ? (11'sd256 - $signed({2'b00, item_q.anchor_x}))
              : -$signed({2'b00, item_q.anchor_x});
    fy   = yi ? (11'sd256 - $signed({2'b00, item_q.anchor_y}))
              : -$signed({2'b00, item_q.anchor_y});
    lx_w = 25'(fx * $signed({1'b0, item_q.size_w}));
    ly_w = 25'(fy * $signed({1'b0, item_q.size_h}));

    geo_d.corner = k_q;
    geo_d.pos_x  = item_q.pos_x;
    geo_d.pos_y  = item_q.pos_y;
    geo_d.lx     = lx_w[23:0];
    geo_d.ly     = ly_w[23:0];
    geo_d.scx    = item_q.scale_x[15] ? 16'sd0 : item_q.scale_x;
    geo_d.scy    = item_q.scale_y[15] ? 16'sd0 : item_q.scale_y;
    geo_d.cosv   = $signed(rom[idx_q][31:16]);
    geo_d.sinv   = $signed(rom[idx_q][15:0]);

    eu = 14'(item_q.src_x) + ((xi ^ item_q.flip[0]) ? 14'(item_q.size_w) : 14'd0);
    ev = 14'(item_q.src_y) + ((yi ^ item_q.flip[1]) ? 14'(item_q.size_h) : 14'd0);

    udiv_d.rem = {1'b0, eu, 16'd0} + sqvg_pkg::NUM_W'(tex_w_i >> 1);
    udiv_d.quo = '0;
    udiv_d.sat = {1'b0, eu} >= {1'b0, tex_w_i, 1'b0};
    vdiv_d.rem = {1'b0, ev, 16'd0} + sqvg_pkg::NUM_W'(tex_h_i >> 1);
    vdiv_d.quo = '0;
    vdiv_d.sat = {1'b0, ev} >= {1'b0, tex_h_i, 1'b0};
  end

  logic a_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= hv_q;
    end
  end

  sqvg_pkg::geo_t geo_q;
  sqvg_pkg::div_t udiv_q;
  sqvg_pkg::div_t vdiv_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      geo_q  <= geo_d;
      udiv_q <= udiv_d;
      vdiv_q <= vdiv_d;
    end
  end

  assign a_valid_o = a_valid_q;
  assign geo_o     = geo_q;
  assign udiv_o    = udiv_q;
  assign vdiv_o    = vdiv_q;

endmodule

### src/sqvg_xform.sv
// Scale, rotate and translate pipeline for one corner per beat
module sqvg_xform (
  input  logic               clk_i,
  input  logic               adv_i,
  input  sqvg_pkg::geo_t     geo_i,
  output logic [1:0]         corner_o,
  output logic signed [23:0] vx_o,
  output logic signed [23:0] vy_o
);

  // stage B: scaling
  logic signed [39:0] qx_q;
  logic signed [39:0] qy_q;
  logic signed [15:0] cb_q;
  logic signed [15:0] sb_q;
  logic signed [23:0] pxb_q;
  logic signed [23:0] pyb_q;
  logic [1:0]         kb_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      qx_q  <= 40'(geo_i.lx * geo_i.scx);
      qy_q  <= 40'(geo_i.ly * geo_i.scy);
      cb_q  <= geo_i.cosv;
      sb_q  <= geo_i.sinv;
      pxb_q <= geo_i.pos_x;
      pyb_q <= geo_i.pos_y;
      kb_q  <= geo_i.corner;
    end
  end

  // stage C: split products
  logic signed [20:0] hx;
  logic signed [19:0] lox;
  logic signed [20:0] hy;
  logic signed [19:0] loy;

  assign hx  = qx_q[39:19];
  assign lox = $signed({1'b0, qx_q[18:0]});
  assign hy  = qy_q[39:19];
  assign loy = $signed({1'b0, qy_q[18:0]});

  logic signed [36:0] xch_q, xcl_q, xsh_q, xsl_q;
  logic signed [36:0] ych_q, ycl_q, ysh_q, ysl_q;
  logic signed [23:0] pxc_q;
  logic signed [23:0] pyc_q;
  logic [1:0]         kc_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      xch_q <= 37'(hx * cb_q);
      xcl_q <= 37'(lox * cb_q);
      xsh_q <= 37'(hx * sb_q);
      xsl_q <= 37'(lox * sb_q);
      ych_q <= 37'(hy * cb_q);
      ycl_q <= 37'(loy * cb_q);
      ysh_q <= 37'(hy * sb_q);
      ysl_q <= 37'(loy * sb_q);
      pxc_q <= pxb_q;
      pyc_q <= pyb_q;
      kc_q  <= kb_q;
    end
  end

  // stage D: rotation sums
  logic signed [55:0] rx_d;
  logic signed [55:0] ry_d;
  logic signed [55:0] rx_q;
  logic signed [55:0] ry_q;
  logic signed [23:0] pxd_q;
  logic signed [23:0] pyd_q;
  logic [1:0]         kd_q;

  assign rx_d = (56'(xch_q) <<< 19) + 56'(xcl_q) - (56'(ysh_q) <<< 19) - 56'(ysl_q);
  assign ry_d = (56'(xsh_q) <<< 19) + 56'(xsl_q) + (56'(ych_q) <<< 19) + 56'(ycl_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      pxd_q <= pxc_q;
      pyd_q <= pyc_q;
      kd_q  <= kc_q;
    end
  end

  // stage E: round, translate, saturate
  function automatic logic signed [23:0] sat24(logic signed [34:0] v);
    if (v > 35'sd8388607) return 24'sh7FFFFF;
    if (v < -35'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  logic signed [55:0] rxr;
  logic signed [55:0] ryr;
  logic signed [34:0] sx;
  logic signed [34:0] sy;

  assign rxr = (rx_q + 56'sd2097152) >>> 22;
  assign ryr = (ry_q + 56'sd2097152) >>> 22;
  assign sx  = 35'($signed(rxr[33:0])) + 35'(pxd_q);
  assign sy  = 35'($signed(ryr[33:0])) + 35'(pyd_q);

  logic signed [23:0] vx_q;
  logic signed [23:0] vy_q;
  logic [1:0]         ke_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vx_q <= sat24(sx);
      vy_q <= sat24(sy);
      ke_q <= kd_q;
    end
  end

  assign corner_o = ke_q;
  assign vx_o     = vx_q;
  assign vy_o     = vy_q;

endmodule

### src/sprite_quad_vertex_generator.sv
// Top level of the sprite quad vertex generator
//
//  channel  | valid / ready          | payload
//  ---------+------------------------+--------------------------
//  in       | in_valid_i/in_ready_o  | in_data_i  (item_t)
//  out      | out_valid_o/out_ready_i| out_data_o (vtx_t)
//  cfg      | cfg_valid_i/cfg_ready_o| cfg_idx_i, cfg_data_i
//
// One sprite beat in gives four corner beats out, one per cycle while the output
// is not stalled. From acceptance a sprite passes the holding stage and the set-up
// register, then four divider/transform stages, before its first corner.
// Reset clears valid bits and sets both texture dimensions to 1.
// A stall on the output freezes every stage; the holding stage still takes a
// new sprite while empty.
`include "sprite_quad_vertex_generator_macros.svh"

module sprite_quad_vertex_generator #(
  parameter int unsigned SINE_TABLE_DEPTH = sqvg_pkg::SINE_DEPTH_DEF,
  parameter int unsigned MAX_TEXTURE_DIM  = sqvg_pkg::MAX_TEX_DIM_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sqvg_pkg::item_t            in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output sqvg_pkg::vtx_t             out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [sqvg_pkg::DIM_W-1:0] cfg_data_i
);

  logic [sqvg_pkg::DIM_W-1:0] tex_w_q;
  logic [sqvg_pkg::DIM_W-1:0] tex_h_q;
  logic [sqvg_pkg::DIM_W-1:0] dim_d;

  always_comb begin
    dim_d = cfg_data_i;
    if (dim_d == '0) dim_d = sqvg_pkg::DIM_W'(1);
    if (int'(dim_d) > int'(MAX_TEXTURE_DIM)) dim_d = sqvg_pkg::DIM_W'(MAX_TEXTURE_DIM);
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q <= sqvg_pkg::DIM_W'(1);
      tex_h_q <= sqvg_pkg::DIM_W'(1);
    end else if (cfg_valid_i) begin
      case (sqvg_pkg::cfg_reg_e'(cfg_idx_i))
        sqvg_pkg::CFG_TEX_W: tex_w_q <= dim_d;
        sqvg_pkg::CFG_TEX_H: tex_h_q <= dim_d;
        default: ;
      endcase
    end
  end

  logic           adv;
  logic           a_valid;
  logic           vb_q;
  logic           vc_q;
  logic           vd_q;
  logic           out_valid_q;
  sqvg_pkg::geo_t geo;
  sqvg_pkg::div_t ud [5];
  sqvg_pkg::div_t vd [5];

  assign adv = !out_valid_q || out_ready_i;

  sqvg_front #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .adv_i     (adv),
    .tex_w_i   (tex_w_q),
    .tex_h_i   (tex_h_q),
    .a_valid_o (a_valid),
    .geo_o     (geo),
    .udiv_o    (ud[0]),
    .vdiv_o    (vd[0])
  );

  localparam int FIRST [4] = '{17, 12, 7, 3};
  localparam int NSTEP [4] = '{5, 5, 4, 4};

  for (genvar s = 0; s < 4; s++) begin : g_div
    sqvg_div_stage #(.FIRST_BIT(FIRST[s]), .STEPS(NSTEP[s])) u_udiv (
      .clk_i(clk_i), .adv_i(adv), .dim_i(tex_w_q), .d_i(ud[s]), .d_o(ud[s+1])
    );
    sqvg_div_stage #(.FIRST_BIT(FIRST[s]), .STEPS(NSTEP[s])) u_vdiv (
      .clk_i(clk_i), .adv_i(adv), .dim_i(tex_h_q), .d_i(vd[s]), .d_o(vd[s+1])
    );
  end

  logic [1:0]         corner;
  logic signed [23:0] vx;
  logic signed [23:0] vy;

  sqvg_xform u_xform (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .geo_i   (geo),
    .corner_o(corner),
    .vx_o    (vx),
    .vy_o    (vy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vb_q        <= a_valid;
      vc_q        <= vb_q;
      vd_q        <= vc_q;
      out_valid_q <= vd_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_data_o.corner   = corner;
  assign out_data_o.vertex_x = vx;
  assign out_data_o.vertex_y = vy;
  assign out_data_o.tex_u    = ud[4].sat ? 17'h1FFFF : ud[4].quo[16:0];
  assign out_data_o.tex_v    = vd[4].sat ? 17'h1FFFF : vd[4].quo[16:0];
  assign out_data_o.last     = (corner == 2'd3);

  `SQVG_ASSERT_IMPL(a_last_on_corner3, out_valid_o, out_data_o.last == (out_data_o.corner == 2'd3))
  `SQVG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `SQVG_ASSERT_IMPL(a_dim_nonzero, 1'b1, tex_w_q != '0 && tex_h_q != '0)

endmodule

### bench/sprite_quad_vertex_generator_chk.sv
// Checker for the sprite quad vertex generator: watches all channels, predicts and compares
module sprite_quad_vertex_generator_chk (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  sqvg_pkg::item_t in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  sqvg_pkg::vtx_t  out_data_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [12:0]     cfg_data_i,
  output int              fail_cnt_o,
  output int              pending_o,
  output int              vtx_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAB_DEPTH = 1024;
  localparam int MAX_DIM   = 4096;

  sqvg_pkg::vtx_t corner_q[$];
  int          tex_w_q;
  int          tex_h_q;
  longint      cos_tab[TAB_DEPTH];
  longint      sin_tab[TAB_DEPTH];

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q14_round(longint v);
    longint r;
    r = shr_floor(v + 32768, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic longint atan_step(int k);
    longint tab [28];
    tab = '{536870912, 316933406, 167458908, 85004756, 42667331, 21354465, 10679838,
            5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
            10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
    return tab[k];
  endfunction

  initial begin
    longint ang, x, y, z, dx, dy;
    bit     neg;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      ang = (longint'(i) <<< 32) / TAB_DEPTH;
      x = 652032874;
      y = 0;
      neg = 1'b0;
      if (ang >= 64'h4000_0000 && ang < 64'hC000_0000) begin
        z = ang - 64'h8000_0000;
        neg = 1'b1;
      end else if (ang < 64'h4000_0000) begin
        z = ang;
      end else begin
        z = ang - 64'h1_0000_0000;
      end
      for (int k = 0; k < 28; k++) begin
        dx = shr_floor(y, k);
        dy = shr_floor(x, k);
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - atan_step(k);
        end else begin
          x = x + dx; y = y - dy; z = z + atan_step(k);
        end
      end
      if (neg) begin
        x = -x; y = -y;
      end
      cos_tab[i] = q14_round(x);
      sin_tab[i] = q14_round(y);
    end
  end

  function automatic logic signed [23:0] sat_q16_8(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return 24'(v);
  endfunction

  function automatic logic [16:0] tex_norm(longint edge_t, int dim);
    longint q;
    q = (edge_t * 65536 + dim / 2) / dim;
    return (q > 131071) ? 17'd131071 : 17'(q);
  endfunction

  function automatic int dim_clamp(logic [12:0] v);
    int d;
    d = int'(v);
    if (d == 0) d = 1;
    if (d > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

  task automatic push_corners(sqvg_pkg::item_t it);
    longint px, py, scx, scy, w, h, ax, ay, c, s, qx, qy, rx, ry;
    longint lx[2], ly[2];
    logic [16:0] u[2], v[2], t;
    int     idx, xi, yi;
    sqvg_pkg::vtx_t vx;
    px  = longint'(it.pos_x);
    py  = longint'(it.pos_y);
    scx = longint'(it.scale_x);
    scy = longint'(it.scale_y);
    if (scx < 0) scx = 0;
    if (scy < 0) scy = 0;
    w  = longint'(it.size_w);
    h  = longint'(it.size_h);
    ax = longint'(it.anchor_x);
    ay = longint'(it.anchor_y);
    lx[0] = -(ax * w);
    lx[1] = w * 256 - ax * w;
    ly[0] = -(ay * h);
    ly[1] = h * 256 - ay * h;
    idx = (int'(it.rotation) * TAB_DEPTH) >> 16;
    c = cos_tab[idx];
    s = sin_tab[idx];
    u[0] = tex_norm(longint'(it.src_x), tex_w_q);
    u[1] = tex_norm(longint'(it.src_x) + w, tex_w_q);
    v[0] = tex_norm(longint'(it.src_y), tex_h_q);
    v[1] = tex_norm(longint'(it.src_y) + h, tex_h_q);
    if (it.flip[0]) begin
      t = u[0]; u[0] = u[1]; u[1] = t;
    end
    if (it.flip[1]) begin
      t = v[0]; v[0] = v[1]; v[1] = t;
    end
    for (int k = 0; k < 4; k++) begin
      xi = (k < 2) ? 1 : 0;
      yi = (k == 1 || k == 2) ? 1 : 0;
      qx = lx[xi] * scx;
      qy = ly[yi] * scy;
      rx = qx * c - qy * s;
      ry = qx * s + qy * c;
      vx.corner   = 2'(k);
      vx.vertex_x = sat_q16_8(shr_floor(rx + (64'sd1 <<< 21), 22) + px);
      vx.vertex_y = sat_q16_8(shr_floor(ry + (64'sd1 <<< 21), 22) + py);
      vx.tex_u    = u[xi];
      vx.tex_v    = v[yi];
      vx.last     = (k == 3);
      corner_q.push_back(vx);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
    vtx_cnt_o  = 0;
    pending_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    sqvg_pkg::vtx_t want;
    if (!rst_ni) begin
      tex_w_q <= 1;
      tex_h_q <= 1;
    end else begin
      if (out_valid_i && out_ready_i) begin
        vtx_cnt_o++;
        if (corner_q.size() == 0) begin
          report_mismatch("unexpected beat, corner", longint'(out_data_i.corner), -1);
        end else begin
          want = corner_q.pop_front();
          if (out_data_i.corner !== want.corner)
            report_mismatch("corner", longint'(out_data_i.corner), longint'(want.corner));
          if (out_data_i.vertex_x !== want.vertex_x)
            report_mismatch("vertex_x", longint'(out_data_i.vertex_x),
                            longint'(want.vertex_x));
          if (out_data_i.vertex_y !== want.vertex_y)
            report_mismatch("vertex_y", longint'(out_data_i.vertex_y),
                            longint'(want.vertex_y));
          if (out_data_i.tex_u !== want.tex_u)
            report_mismatch("tex_u", longint'(out_data_i.tex_u), longint'(want.tex_u));
          if (out_data_i.tex_v !== want.tex_v)
            report_mismatch("tex_v", longint'(out_data_i.tex_v), longint'(want.tex_v));
          if (out_data_i.last !== want.last)
            report_mismatch("last", longint'(out_data_i.last), longint'(want.last));
        end
      end
      if (in_valid_i && in_ready_i) push_corners(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_idx_i == sqvg_pkg::CFG_TEX_W) tex_w_q <= dim_clamp(cfg_data_i);
        else if (cfg_idx_i == sqvg_pkg::CFG_TEX_H) tex_h_q <= dim_clamp(cfg_data_i);
      end
      pending_o = corner_q.size();
    end
  end
endmodule

### bench/sprite_quad_vertex_generator_tb.sv
// Testbench top for the sprite quad vertex generator: stimulus, idling and verdict
module sprite_quad_vertex_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  sqvg_pkg::item_t in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  sqvg_pkg::vtx_t out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;
  int         fail_cnt, pending, vtx_cnt;
  int         sprite_cnt = 0;
  int         cfg_cnt = 0;
  int         idle_cycles = 0;
  bit         hold_off = 1'b0;
  bit         stim_done = 1'b0;

  always #6 clk_i = ~clk_i;

  sprite_quad_vertex_generator uut (.*);

  sprite_quad_vertex_generator_chk chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_idx_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .vtx_cnt_o(vtx_cnt)
  );

  // receiver stall pattern
  initial begin
    int mode;
    forever begin
      @(posedge clk_i);
      if (hold_off) out_ready_i <= 1'b0;
      else begin
        mode = (sprite_cnt / 40) % 3;
        if (mode == 0) out_ready_i <= 1'b1;
        else if (mode == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
        else out_ready_i <= ($urandom_range(0, 1) == 1);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired, %0d corners outstanding", pending);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_sprite(sqvg_pkg::item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sprite_cnt++;
  endtask

  task automatic pause_sender();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(sqvg_pkg::cfg_reg_e idx, logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_cnt++;
  endtask

  function automatic sqvg_pkg::item_t rand_sprite(bit wide);
    sqvg_pkg::item_t it;
    it.pos_x    = 24'($urandom);
    it.pos_y    = 24'($urandom);
    it.rotation = 16'($urandom);
    it.scale_x  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
    it.scale_y  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
    it.size_w   = wide ? 13'($urandom) : 13'($urandom_range(0, 4096));
    it.size_h   = wide ? 13'($urandom) : 13'($urandom_range(0, 4096));
    it.src_x    = 12'($urandom);
    it.src_y    = 12'($urandom);
    it.anchor_x = wide ? 9'($urandom) : 9'($urandom_range(0, 256));
    it.anchor_y = wide ? 9'($urandom) : 9'($urandom_range(0, 256));
    it.flip     = 2'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      it.pos_x = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      it.pos_y = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
    end
    return it;
  endfunction

  initial begin
    sqvg_pkg::item_t it;
    int    dims [6];
    dims = '{1, 4096, 0, 8191, 256, 3000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners of the field ranges
    for (int i = 0; i < 20; i++) begin
      it = '0;
      it.size_w = 13'd16; it.size_h = 13'd8; it.scale_x = 16'sd256; it.scale_y = 16'sd256;
      it.anchor_x = 9'd128; it.anchor_y = 9'd128;
      it.rotation = 16'(i * 4096);
      it.flip = 2'(i);
      case (i)
        0: begin it.pos_x = 24'h7fffff; it.pos_y = 24'h800000; end
        1: begin it.pos_x = 24'h800000; it.pos_y = 24'h7fffff; end
        2: begin it.scale_x = 16'h8000; it.scale_y = -16'sd1; end
        3: begin it.scale_x = 16'h7fff; it.scale_y = 16'h7fff; it.size_w = 13'd4096; end
        4: begin it.size_w = 13'h1fff; it.size_h = 13'h1fff; it.anchor_x = 9'h1ff; end
        5: begin it.src_x = 12'hfff; it.src_y = 12'hfff; it.size_w = 13'd4096; end
        6: begin it.anchor_x = 9'd256; it.anchor_y = 9'd0; end
        7: begin it.size_w = 13'd0; it.size_h = 13'd0; end
        8: it.rotation = 16'hffff;
        9: begin it.rotation = 16'h0040; it.anchor_y = 9'h1ff; end
        default: it.pos_x = 24'($urandom);
      endcase
      send_sprite(it);
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(sqvg_pkg::CFG_TEX_W, 13'(dims[ph]));
      write_reg(sqvg_pkg::CFG_TEX_H, 13'(dims[5 - ph]));
      if (ph == 3) write_reg(sqvg_pkg::cfg_reg_e'(2'd3), 13'd77);
      for (int n = 0; n < 48; n++) begin
        if (ph == 2 && n == 10) begin
          // long receiver hold-off while the sender keeps offering
          hold_off = 1'b1;
          fork
            begin
              repeat (200) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        if ($urandom_range(0, 5) == 0) pause_sender();
        send_sprite(rand_sprite($urandom_range(0, 9) == 0));
      end
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("covered %0d sprites, %0d corner beats, %0d register writes",
             sprite_cnt, vtx_cnt, cfg_cnt);
    if (fail_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
